// ----- hdl/qee_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qee_pkg
// Types and constants shared by the quadrature encoder emulator modules.
// ----------------------------------------------------------------------------
package qee_pkg;

  localparam int IN_W      = 40;
  localparam int OUT_W     = 24;
  localparam int CFG_W     = 16;
  localparam int REG_IDX_W = 1;

  localparam logic [15:0] SPEED_NUM          = 16'd48000;
  localparam logic [15:0] MIN_DUTY           = 16'd40;
  localparam logic [7:0]  APPROACH_DIV_RESET = 8'd8;
  localparam logic [15:0] START_PERIOD_RESET = 16'hFFFF;

  localparam logic [REG_IDX_W-1:0] REG_APPROACH_DIV = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_START_PERIOD = 1'b1;

  localparam logic [1:0] STEP_NONE = 2'b00;
  localparam logic [1:0] STEP_FWD  = 2'b01;
  localparam logic [1:0] STEP_REV  = 2'b11;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TGT,
    S_TGT_WAIT,
    S_APP,
    S_APP_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic tgt_start;
    logic tgt_write;
    logic app_start;
    logic upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic tgt_needed;
    logic div_done;
  } sts_t;

endpackage

// ----- hdl/qee_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qee_div
// Restoring radix-2 divider, one quotient bit per cycle, 16-bit divisor.
// ----------------------------------------------------------------------------
module qee_div #(
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [15:0]   divisor,
  output logic [DW-1:0] quotient,
  output logic [15:0]   remainder,
  output logic          done
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r, q_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [15:0]   dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [16:0]   trial;

  always_comb begin
    trial    = {rem_r, q_r[DW-1]};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 16'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient  = q_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

// ----- hdl/qee_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qee_dp
// Datapath: input latch, period registers, quadrature position, output word.
// ----------------------------------------------------------------------------
module qee_dp #(
  parameter int PERIOD_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [qee_pkg::IN_W-1:0]         in_tdata,
  output logic [qee_pkg::OUT_W-1:0]        out_tdata,
  input  logic                             cfg_we,
  input  logic [qee_pkg::REG_IDX_W-1:0]    cfg_addr,
  input  logic [qee_pkg::CFG_W-1:0]        cfg_wdata,
  input  qee_pkg::cmd_t                    cmd,
  output qee_pkg::sts_t                    sts
);

  import qee_pkg::*;

  localparam int PW = PERIOD_WIDTH;
  localparam int DW = (PERIOD_WIDTH > 16) ? PERIOD_WIDTH : 16;

  dir_t        dir_r;
  logic [15:0] duty_r;
  logic [7:0]  adiv_r;
  logic [PW-1:0] cur_r, tgt_r;
  logic [1:0]  pos_r, pos_nxt;
  logic [15:0] period_out_r;
  logic        enc_a_r, enc_b_r;
  logic [1:0]  step_out_r;

  dir_t        in_dir;
  logic [15:0] in_duty_cw, in_duty_ccw;
  logic [1:0]  step;
  logic        ge;
  logic [PW-1:0] diff, cur_nxt;
  logic [7:0]  dvs_eff;
  logic        div_start;
  logic [DW-1:0] div_dividend, div_q;
  logic [15:0] div_divisor, div_rem;
  logic        div_done;
  logic [PW-1:0] q_pw;

  assign in_dir      = dir_t'(in_tdata[1:0]);
  assign in_duty_cw  = in_tdata[17:2];
  assign in_duty_ccw = in_tdata[33:18];

  always_comb begin
    case (dir_r)
      DIR_CW:  step = STEP_FWD;
      DIR_CCW: step = STEP_REV;
      default: step = STEP_NONE;
    endcase
  end

  // period error and the effective divisor
  assign ge      = (tgt_r >= cur_r);
  assign diff    = ge ? (tgt_r - cur_r) : (cur_r - tgt_r);
  assign dvs_eff = (adiv_r == 8'd0) ? 8'd1 : adiv_r;

  assign div_start    = cmd.tgt_start | cmd.app_start;
  assign div_dividend = cmd.app_start ? DW'(diff) : DW'(SPEED_NUM);
  assign div_divisor  = cmd.app_start ? 16'(dvs_eff) : duty_r;

  qee_div #(
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .remainder(div_rem),
    .done     (div_done)
  );

  assign q_pw = div_q[PW-1:0];

  // floor toward the target, rounding away from zero when moving down
  always_comb begin
    if (ge) begin
      cur_nxt = cur_r + q_pw;
    end else begin
      cur_nxt = cur_r - q_pw - PW'(div_rem != 16'd0);
    end
  end

  assign pos_nxt = pos_r + step;

  assign sts.tgt_needed = (dir_r == DIR_CW || dir_r == DIR_CCW) && (duty_r > MIN_DUTY);
  assign sts.div_done   = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adiv_r <= APPROACH_DIV_RESET;
      cur_r  <= PW'(START_PERIOD_RESET);
      tgt_r  <= '0;
      pos_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_APPROACH_DIV: adiv_r <= cfg_wdata[7:0];
          REG_START_PERIOD: cur_r  <= PW'(cfg_wdata);
        endcase
      end
      if (cmd.tgt_write) begin
        tgt_r <= q_pw;
      end
      if (cmd.upd) begin
        cur_r <= cur_nxt;
        pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dir_r  <= in_dir;
      duty_r <= (in_dir == DIR_CCW) ? in_duty_ccw : in_duty_cw;
    end
    if (cmd.out_load) begin
      period_out_r <= 16'(32'(cur_r));
      enc_a_r      <= (pos_r <= 2'd1);
      enc_b_r      <= (pos_r == 2'd0) || (pos_r == 2'd3);
      step_out_r   <= step;
    end
  end

  assign out_tdata = {4'b0, step_out_r, enc_b_r, enc_a_r, period_out_r};

endmodule

// ----- hdl/qee_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qee_ctrl
// Sequencer: optional target division, approach division, update, hand-off.
// ----------------------------------------------------------------------------
module qee_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output qee_pkg::cmd_t cmd,
  input  qee_pkg::sts_t sts
);

  import qee_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_TGT;
        end
      end
      S_TGT: begin
        if (sts.tgt_needed) begin
          cmd.tgt_start = 1'b1;
          state_nxt     = S_TGT_WAIT;
        end else begin
          state_nxt = S_APP;
        end
      end
      S_TGT_WAIT: begin
        if (sts.div_done) begin
          cmd.tgt_write = 1'b1;
          state_nxt     = S_APP;
        end
      end
      S_APP: begin
        cmd.app_start = 1'b1;
        state_nxt     = S_APP_WAIT;
      end
      S_APP_WAIT: begin
        if (sts.div_done) begin
          cmd.upd   = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- hdl/quadrature_encoder_emulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_encoder_emulator
// Per timer tick: recompute the target period from the duty, approach it,
// step the quadrature position and report period, encoder levels and step.
// The word is accepted in S_IDLE, then the serial divider computes the
// target (skipped when it is kept) and the approach step before S_OUT.
// A new word is accepted only once S_OUT has loaded the previous result; a
// new word is taken while a result waits.
// Reset: synchronous active-low rst_n; divisor 8, period 65535, target and
// position zero.
// ----------------------------------------------------------------------------
module quadrature_encoder_emulator #(
  parameter int PERIOD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // command[1:0], duty_cw[17:2], duty_ccw[33:18], zero fill
  input  logic [qee_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // new_period[15:0], enc_a[16], enc_b[17], motor_step[19:18], zero fill
  output logic [qee_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_we,
  input  logic [qee_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [qee_pkg::CFG_W-1:0]     cfg_wdata
);

  import qee_pkg::*;

  cmd_t cmd;
  sts_t sts;

  qee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  qee_dp #(
    .PERIOD_WIDTH(PERIOD_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tdata (in_tdata),
    .out_tdata(out_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
